/* rtl/twbq_pkg.sv */
// twbq_pkg: shared types and constants for the trigger window burst qualifier
// no dependencies; used by every module under rtl and by the bench
`timescale 1ns / 1ps

package twbq_pkg;

  localparam int unsigned SampleW   = 10;
  localparam int unsigned CheatW    = 11;
  localparam int unsigned HoldoffW  = 16;
  localparam int unsigned BurstW    = 8;
  localparam int unsigned IdW       = 8;
  localparam int unsigned CountW    = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CheatW-1:0] CheatLimitRst = 11'd1024;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PRESS_THRESHOLD = 3'd0,
    REG_CHEAT_LIMIT     = 3'd1,
    REG_HOLDOFF_SAMPLES = 3'd2,
    REG_BURST_LIMIT     = 3'd3,
    REG_PLAYER_ID       = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    LED_KEEP = 2'd0,
    LED_RED  = 2'd1,
    LED_OFF  = 2'd2
  } led_cmd_e;

  typedef struct packed {
    logic [SampleW-1:0] sample;
  } sample_t;

  typedef struct packed {
    logic           pressed;
    logic           shot_valid;
    logic [IdW-1:0] shot_byte;
    led_cmd_e       led_command;
    logic           sound_start;
    logic           sound_repeat;
    logic           sound_stop;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  // current register values, handed from the register file to the datapath
  typedef struct packed {
    logic [SampleW-1:0]  press_threshold;
    logic [CheatW-1:0]   cheat_limit;
    logic [HoldoffW-1:0] holdoff_samples;
    logic [BurstW-1:0]   burst_limit;
    logic [IdW-1:0]      player_id;
  } cfg_t;

endpackage

/* rtl/twbq_stream_if.sv */
// twbq_stream_if: valid/ready channel carrying one payload beat
// depends on nothing; payload type given by the instantiating code
`timescale 1ns / 1ps

interface twbq_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/trigger_window_burst_qualifier.sv */
// Trigger window burst qualifier. One sample beat in gives one result beat out,
// and a new sample can be taken every clock cycle while results are taken. A sample
// passes the input register, the single compare-and-count step and the result register.
// The result register lets a new sample in while a result waits
// to be taken. Configuration writes are taken every cycle and should only be
// made while no sample is in flight. No clearing pass is needed after reset.
// depends on twbq_pkg, twbq_stream_if and twbq_cfg_regs
`timescale 1ns / 1ps

module trigger_window_burst_qualifier
  import twbq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  twbq_stream_if.sink   smp_i,
  twbq_stream_if.source res_o,
  twbq_stream_if.sink   cfg_i
);

  cfg_t cfg;

  twbq_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  logic               in_valid_q;
  logic [SampleW-1:0] in_sample_q;
  logic               out_valid_q;
  result_t            out_q;
  logic [CountW-1:0]  hold_q, hold_d;
  logic [CountW-1:0]  shot_q, shot_d;
  result_t            res_d;
  logic               advance;
  logic               pressed;
  logic               unlimited;

  // the input stage moves on when the result register is free or being emptied
  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign smp_i.ready = !in_valid_q || advance;

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  assign pressed   = (in_sample_q > cfg.press_threshold) &&
                     ({1'b0, in_sample_q} < cfg.cheat_limit);
  assign unlimited = (cfg.burst_limit == '0);

  always_comb begin
    res_d         = '0;
    res_d.pressed = pressed;
    res_d.led_command = LED_KEEP;
    hold_d        = hold_q;
    shot_d        = shot_q;
    if (pressed) begin
      if (hold_q < cfg.holdoff_samples) begin
        hold_d = hold_q + 1'b1;
      end else if (unlimited || shot_q <= {{(CountW-BurstW){1'b0}}, cfg.burst_limit}) begin
        if (shot_q == '0) begin
          res_d.led_command  = LED_RED;
          res_d.sound_start  = 1'b1;
          res_d.sound_repeat = unlimited;
        end
        res_d.shot_valid = 1'b1;
        res_d.shot_byte  = cfg.player_id;
        // saturate rather than wrap
        if (shot_q != '1) begin
          shot_d = shot_q + 1'b1;
        end
      end else begin
        res_d.led_command = LED_OFF;
      end
    end else begin
      // release
      res_d.led_command = LED_OFF;
      res_d.sound_stop  = unlimited && (shot_q != '0);
      hold_d            = '0;
      shot_d            = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hold_q      <= '0;
      shot_q      <= '0;
    end else begin
      if (smp_i.ready) begin
        in_valid_q <= smp_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        hold_q      <= hold_d;
        shot_q      <= shot_d;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_i.valid && smp_i.ready) begin
      in_sample_q <= smp_i.data.sample;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

endmodule

/* rtl/twbq_cfg_regs.sv */
// twbq_cfg_regs: configuration register file of the burst qualifier
// depends on twbq_pkg and twbq_stream_if
`timescale 1ns / 1ps

module twbq_cfg_regs
  import twbq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  twbq_stream_if.sink cfg_i,
  output cfg_t  cfg_o
);

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_threshold <= '0;
      cfg_q.cheat_limit     <= CheatLimitRst;
      cfg_q.holdoff_samples <= '0;
      cfg_q.burst_limit     <= '0;
      cfg_q.player_id       <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.data.index))
        REG_PRESS_THRESHOLD: cfg_q.press_threshold <= cfg_i.data.data[SampleW-1:0];
        REG_CHEAT_LIMIT:     cfg_q.cheat_limit     <= cfg_i.data.data[CheatW-1:0];
        REG_HOLDOFF_SAMPLES: cfg_q.holdoff_samples <= cfg_i.data.data[HoldoffW-1:0];
        REG_BURST_LIMIT:     cfg_q.burst_limit     <= cfg_i.data.data[BurstW-1:0];
        REG_PLAYER_ID:       cfg_q.player_id       <= cfg_i.data.data[IdW-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sim/trigger_window_burst_qualifier_test.sv */
// trigger_window_burst_qualifier_test: self-checking bench for the trigger qualifier,
// with a per-sample predictor, random sample presses and register changes between phases
// depends on twbq_pkg, twbq_stream_if and trigger_window_burst_qualifier under rtl
`timescale 1ns / 1ps

module trigger_window_burst_qualifier_test;
  import twbq_pkg::*;

  localparam int unsigned NumRegs    = 5;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned Drain      = 4;

  logic clk_i;
  logic rst_ni;

  twbq_stream_if #(.T(sample_t)) smp ();
  twbq_stream_if #(.T(result_t)) res ();
  twbq_stream_if #(.T(cfg_wr_t)) cfg ();

  trigger_window_burst_qualifier u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .smp_i  (smp),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  // predictor copy of the registers and counters
  logic [SampleW-1:0]  cfg_thr   = '0;
  logic [CheatW-1:0]   cfg_cheat = CheatLimitRst;
  logic [HoldoffW-1:0] cfg_hold  = '0;
  logic [BurstW-1:0]   cfg_burst = '0;
  logic [IdW-1:0]      cfg_id    = '0;
  logic [CountW-1:0]   hold_cnt  = '0;
  logic [CountW-1:0]   shot_cnt  = '0;

  logic [SampleW-1:0] sample_q[$];
  result_t            due_results[$];

  int unsigned tx_idle = 0;
  int unsigned rx_idle = 0;
  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_errors = 0;
  int unsigned n_shots = 0;
  int unsigned n_releases = 0;
  int unsigned n_stops = 0;
  int unsigned n_writes = 0;
  int unsigned n_cycles = 0;
  logic        smp_beat = 1'b0;
  logic        cfg_beat = 1'b0;

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles == CycleLimit) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("trigger_window_burst_qualifier_test failed");
      $finish;
    end
  end

  function automatic result_t qualify_sample(input logic [SampleW-1:0] s);
    result_t r;
    logic    hit;
    r = '0;
    r.led_command = LED_KEEP;
    hit = (s > cfg_thr) && ({1'b0, s} < cfg_cheat);
    r.pressed = hit;
    if (hit) begin
      if (hold_cnt < cfg_hold) begin
        hold_cnt = hold_cnt + 1'b1;
      end else if (cfg_burst == '0 || shot_cnt <= CountW'(cfg_burst)) begin
        if (shot_cnt == '0) begin
          r.led_command  = LED_RED;
          r.sound_start  = 1'b1;
          r.sound_repeat = (cfg_burst == '0);
        end
        r.shot_valid = 1'b1;
        r.shot_byte  = cfg_id;
        // counter sticks at its ceiling
        if (shot_cnt != '1) shot_cnt = shot_cnt + 1'b1;
      end else begin
        r.led_command = LED_OFF;
      end
    end else begin
      r.led_command = LED_OFF;
      r.sound_stop  = (cfg_burst == '0) && (shot_cnt != '0);
      hold_cnt = '0;
      shot_cnt = '0;
    end
    return r;
  endfunction

  task automatic note_error(input string msg);
    n_errors++;
    if (n_errors <= MaxReports) $display("%s", msg);
  endtask

  // beats are taken at the rising edge
  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    smp_beat <= smp.valid && smp.ready;
    cfg_beat <= cfg.valid && cfg.ready;
    if (rst_ni) begin
      if (cfg.valid && cfg.ready) begin
        n_writes++;
        case (cfg.data.index)
          REG_PRESS_THRESHOLD: cfg_thr   = cfg.data.data[SampleW-1:0];
          REG_CHEAT_LIMIT:     cfg_cheat = cfg.data.data[CheatW-1:0];
          REG_HOLDOFF_SAMPLES: cfg_hold  = cfg.data.data[HoldoffW-1:0];
          REG_BURST_LIMIT:     cfg_burst = cfg.data.data[BurstW-1:0];
          REG_PLAYER_ID:       cfg_id    = cfg.data.data[IdW-1:0];
          default: ;
        endcase
      end
      if (smp.valid && smp.ready) begin
        want = qualify_sample(smp.data.sample);
        due_results.push_back(want);
        n_accepted++;
        n_shots    += want.shot_valid;
        n_releases += !want.pressed;
        n_stops    += want.sound_stop;
      end
      if (res.valid && res.ready) begin
        got = res.data;
        n_results++;
        if (due_results.size() == 0) begin
          note_error($sformatf("result %0d arrived with nothing due: %p", n_results, got));
        end else begin
          want = due_results.pop_front();
          if (got.pressed !== want.pressed || got.shot_valid !== want.shot_valid ||
              got.shot_byte !== want.shot_byte || got.led_command !== want.led_command ||
              got.sound_start !== want.sound_start ||
              got.sound_repeat !== want.sound_repeat ||
              got.sound_stop !== want.sound_stop)
            note_error($sformatf("result %0d mismatch: expected %p, got %p",
                                 n_results, want, got));
        end
      end
    end
  end

  // sample source and result sink change at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      res.ready <= ($urandom_range(99) >= rx_idle);
      if (!smp.valid || smp_beat) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= tx_idle) begin
          smp.valid       <= 1'b1;
          smp.data.sample <= sample_q.pop_front();
        end else begin
          smp.valid <= 1'b0;
        end
      end
    end
  end

  task automatic queue_sample(input logic [SampleW-1:0] v);
    sample_q.push_back(v);
    n_queued++;
  endtask

  task automatic settle(input int unsigned extra);
    do @(negedge clk_i); while (n_accepted != n_queued || due_results.size() != 0);
    repeat (extra) @(negedge clk_i);
  endtask

  // unused upper data bits carry junk, which the register must drop
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val,
                           input int unsigned bits);
    logic [CfgDataW-1:0] word;
    word = CfgDataW'(($urandom() << bits) | val);
    @(negedge clk_i);
    cfg.valid <= 1'b1;
    cfg.data  <= '{index: idx, data: word};
    do @(negedge clk_i); while (!cfg_beat);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_all(input int unsigned thr, input int unsigned cheat,
                         input int unsigned hold, input int unsigned burst,
                         input int unsigned id);
    write_reg(REG_PRESS_THRESHOLD, thr, SampleW);
    write_reg(REG_CHEAT_LIMIT, cheat, CheatW);
    write_reg(REG_HOLDOFF_SAMPLES, hold, HoldoffW);
    write_reg(REG_BURST_LIMIT, burst, BurstW);
    write_reg(REG_PLAYER_ID, id, IdW);
  endtask

  task automatic pick_window();
    int unsigned k;
    int unsigned thr;
    int unsigned cheat;
    k = $urandom_range(9);
    thr = (k == 0) ? 0 : (k == 1) ? 1023 : $urandom_range(800);
    if (k == 0)      cheat = $urandom_range(1) ? 1024 : 2047;
    else if (k == 1) cheat = 1024;
    else if (k == 2) cheat = 0;
    else             cheat = thr + 2 + $urandom_range(300);
    set_all(thr, cheat,
            ($urandom_range(7) == 0) ? $urandom_range(20, 4) : $urandom_range(3),
            ($urandom_range(9) == 0) ? 255 : $urandom_range(4),
            $urandom_range(255));
  endtask

  // one press inside the window, a few stray or edge readings, then a release
  task automatic queue_press();
    int lo;
    int hi;
    int len;
    int r;
    int v;
    lo = int'(cfg_thr) + 1;
    hi = int'(cfg_cheat) - 1;
    if (hi > 1023) hi = 1023;
    len = $urandom_range(int'(cfg_hold) + ((cfg_burst == '0) ? 6 : int'(cfg_burst)) + 3, 1);
    if (len > 40) len = 40;
    repeat (len) begin
      r = $urandom_range(99);
      if (lo <= hi && r < 88) v = $urandom_range(hi, lo);
      else if (r < 94)        v = $urandom_range(1023);
      else begin
        case ($urandom_range(3))
          0:       v = cfg_thr;
          1:       v = lo;
          2:       v = hi;
          default: v = cfg_cheat;
        endcase
      end
      queue_sample(SampleW'(v));
    end
    repeat ($urandom_range(2, 1)) begin
      if (cfg_cheat <= 1023 && $urandom_range(1)) v = $urandom_range(1023, cfg_cheat);
      else                                        v = $urandom_range(cfg_thr);
      queue_sample(SampleW'(v));
    end
  endtask

  initial begin
    int unsigned target;
    bit          held;
    held      = 1'b0;
    smp.valid = 1'b0;
    smp.data  = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.data  = '0;
    rst_ni    = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: full window, unlimited burst, sound stop on release
    queue_sample(10'd0);
    queue_sample(10'd1);
    queue_sample(10'd1023);
    queue_sample(10'd512);
    queue_sample(10'd0);
    settle(Drain);

    // holdoff of two, then two shots, then led off, release on the window edges
    set_all(100, 900, 2, 1, 8'hA5);
    queue_sample(10'd100);
    queue_sample(10'd101);
    queue_sample(10'd899);
    queue_sample(10'd500);
    queue_sample(10'd500);
    queue_sample(10'd500);
    queue_sample(10'd500);
    queue_sample(10'd900);
    settle(Drain);

    // empty window both ways
    write_reg(REG_PRESS_THRESHOLD, 1023, SampleW);
    write_reg(REG_CHEAT_LIMIT, 1024, CheatW);
    queue_sample(10'd1023);
    queue_sample(10'd0);
    settle(Drain);
    write_reg(REG_PRESS_THRESHOLD, 0, SampleW);
    write_reg(REG_CHEAT_LIMIT, 0, CheatW);
    queue_sample(10'd0);
    settle(Drain);

    // index beyond the register file must leave everything alone
    write_reg(REG_CHEAT_LIMIT, 1024, CheatW);
    write_reg(CfgIdxW'($urandom_range((1 << CfgIdxW) - 1, NumRegs)), 0, 0);
    queue_sample(10'd512);
    queue_sample(10'd0);
    settle(Drain);

    // long holdoff, then an unlimited press and a release that stops the sound
    set_all(0, 1024, 40, 0, 255);
    repeat (60) queue_sample(SampleW'($urandom_range(1023, 1)));
    queue_sample(10'd0);
    settle(Drain);

    // widest finite burst, run past its limit
    write_reg(REG_HOLDOFF_SAMPLES, 0, HoldoffW);
    write_reg(REG_BURST_LIMIT, 255, BurstW);
    repeat (258) queue_sample(SampleW'($urandom_range(1023, 1)));
    queue_sample(10'd0);
    settle(Drain);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 29 : (ph == 1) ? 49 : 0;
      rx_idle = (ph == 0) ? 49 : (ph == 1) ? 29 : 0;
      for (int k = 0; k < 2; k++) begin
        settle(Drain);
        pick_window();
        target = n_queued + 115;
        while (n_queued < target) begin
          queue_press();
          // sender holds back once until every result is in
          if (ph == 0 && k == 1 && !held && n_queued + 60 >= target) begin
            settle(0);
            held = 1'b1;
          end
        end
      end
    end
    settle(Drain + 2);

    $display("covered %0d samples over %0d register writes: %0d shots, %0d releases,",
             n_accepted, n_writes, n_shots, n_releases);
    $display("%0d sound stops, %0d results checked, %0d mismatches",
             n_stops, n_results, n_errors);
    if (n_errors == 0) begin
      $display("trigger_window_burst_qualifier_test passed");
    end else begin
      $display("trigger_window_burst_qualifier_test failed");
    end
    $finish;
  end

endmodule
